FILE: hdl/mrpt_pkg.sv
`timescale 1ns / 1ps
package mrpt_pkg;
  localparam int WIDTH = 64;
  localparam int NUM_BASES = 12;
  localparam int BIT_W = $clog2(WIDTH);
  localparam int R_W = $clog2(WIDTH + 1);
  localparam int BASE_W = $clog2(NUM_BASES + 1);

  typedef logic [WIDTH-1:0] word_t;

  function automatic logic [5:0] base_at(input logic [BASE_W-1:0] k);
    logic [5:0] v;
    case (k)
      4'd0: v = 6'd2;
      4'd1: v = 6'd3;
      4'd2: v = 6'd5;
      4'd3: v = 6'd7;
      4'd4: v = 6'd11;
      4'd5: v = 6'd13;
      4'd6: v = 6'd17;
      4'd7: v = 6'd19;
      4'd8: v = 6'd23;
      4'd9: v = 6'd29;
      4'd10: v = 6'd31;
      4'd11: v = 6'd37;
      default: v = 6'd0;
    endcase
    return v;
  endfunction
endpackage

FILE: hdl/mrpt_if.sv
`timescale 1ns / 1ps
interface mrpt_in_if;
  logic valid;
  logic ready;
  logic [63:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

FILE: hdl/miller_rabin_prime_test.sv
`timescale 1ns / 1ps
// Deterministic Miller-Rabin primality test for one 64-bit unsigned
// candidate per transfer; returns is_prime. Bases 2..37 are tried in order,
// stopping at the first base above n-2 or at the first failing base. All
// modular arithmetic runs on one shared modular add unit. Each modular
// multiply is a shift-add over 64 bits, most significant bit first: each
// bit doubles the partial product, and each set multiplier bit adds the
// multiplicand once more. For each base, every exponent bit of d costs
// one squaring, and each set bit costs one more multiply. Up to r-1
// squarings follow, so a base needs at most about 127 multiplies. Trivial
// cases (n below 4, or n even) finish without any multiply.
// One item is in flight at a time; in_ready is low while it runs, and the
// result sits in an output register until its transfer.
module miller_rabin_prime_test (
  input logic clk,
  input logic rst_n,
  mrpt_in_if.sink in_ch,
  mrpt_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_BASE, S_POW, S_MUL_DBL, S_MUL_ADD, S_MUL_DONE,
    S_CHECK, S_SQR, S_OUT
  } state_t;

  // what the active multiply feeds
  typedef enum logic [1:0] {
    M_ACC, M_SQB, M_SQX
  } mop_t;

  state_t state_r;
  mop_t mop_r;
  mrpt_pkg::word_t n_r, d_r, e_r, b_r, acc_r, x_r, mx_r, my_r, mp_r;
  logic [mrpt_pkg::R_W-1:0] r_r, i_r;
  logic [mrpt_pkg::BIT_W-1:0] bit_r;
  logic [mrpt_pkg::BASE_W-1:0] k_r;
  logic prime_r, out_valid_r;

  // shared modular adder: (p + q) mod n for p, q < n
  mrpt_pkg::word_t add_p, add_q, room, add_res;
  always_comb begin
    add_p = mp_r;
    add_q = (state_r == S_MUL_DBL) ? mp_r : mx_r;
    room = n_r - add_q;
    add_res = (add_p >= room) ? (add_p - room) : (add_p + add_q);
  end

  mrpt_pkg::word_t nm1, nm2, base_w;
  always_comb begin
    nm1 = n_r - mrpt_pkg::WIDTH'(1);
    nm2 = n_r - mrpt_pkg::WIDTH'(2);
    base_w = mrpt_pkg::WIDTH'(mrpt_pkg::base_at(k_r));
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.is_prime = prime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      mop_r <= M_ACC;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            n_r <= in_ch.candidate[mrpt_pkg::WIDTH-1:0];
            state_r <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (n_r == mrpt_pkg::WIDTH'(2) || n_r == mrpt_pkg::WIDTH'(3)) begin
            prime_r <= 1'b1;
            state_r <= S_OUT;
          end else if (n_r <= mrpt_pkg::WIDTH'(1) || !n_r[0]) begin
            prime_r <= 1'b0;
            state_r <= S_OUT;
          end else begin
            d_r <= nm1;
            r_r <= '0;
            k_r <= '0;
            state_r <= S_BASE;
          end
        end
        S_BASE: begin
          // strip one factor of two per cycle first
          if (!d_r[0]) begin
            d_r <= d_r >> 1;
            r_r <= r_r + 1'b1;
          end else if (k_r == mrpt_pkg::BASE_W'(mrpt_pkg::NUM_BASES) || base_w > nm2) begin
            prime_r <= 1'b1;
            state_r <= S_OUT;
          end else begin
            acc_r <= mrpt_pkg::WIDTH'(1);
            b_r <= base_w;
            e_r <= d_r;
            state_r <= S_POW;
          end
        end
        S_POW: begin
          if (e_r == '0) begin
            x_r <= acc_r;
            i_r <= mrpt_pkg::R_W'(1);
            state_r <= S_CHECK;
          end else begin
            mop_r <= e_r[0] ? M_ACC : M_SQB;
            mx_r <= e_r[0] ? acc_r : b_r;
            my_r <= b_r;
            mp_r <= '0;
            bit_r <= mrpt_pkg::BIT_W'(mrpt_pkg::WIDTH - 1);
            state_r <= S_MUL_DBL;
          end
        end
        S_MUL_DBL: begin
          mp_r <= add_res;
          if (my_r[bit_r]) state_r <= S_MUL_ADD;
          else if (bit_r == '0) state_r <= S_MUL_DONE;
          else bit_r <= bit_r - 1'b1;
        end
        S_MUL_ADD: begin
          mp_r <= add_res;
          if (bit_r == '0) state_r <= S_MUL_DONE;
          else begin
            bit_r <= bit_r - 1'b1;
            state_r <= S_MUL_DBL;
          end
        end
        S_MUL_DONE: begin
          unique case (mop_r)
            M_ACC: begin
              // acc updated; now square the base
              acc_r <= mp_r;
              mop_r <= M_SQB;
              mx_r <= b_r;
              my_r <= b_r;
              mp_r <= '0;
              bit_r <= mrpt_pkg::BIT_W'(mrpt_pkg::WIDTH - 1);
              state_r <= S_MUL_DBL;
            end
            M_SQB: begin
              b_r <= mp_r;
              e_r <= e_r >> 1;
              state_r <= S_POW;
            end
            default: begin
              x_r <= mp_r;
              i_r <= i_r + 1'b1;
              state_r <= S_SQR;
            end
          endcase
        end
        S_CHECK: begin
          if (x_r == mrpt_pkg::WIDTH'(1) || x_r == nm1) begin
            k_r <= k_r + 1'b1;
            state_r <= S_BASE;
          end else if (i_r < r_r) begin
            mop_r <= M_SQX;
            mx_r <= x_r;
            my_r <= x_r;
            mp_r <= '0;
            bit_r <= mrpt_pkg::BIT_W'(mrpt_pkg::WIDTH - 1);
            state_r <= S_MUL_DBL;
          end else begin
            prime_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_SQR: begin
          if (x_r == nm1) begin
            k_r <= k_r + 1'b1;
            state_r <= S_BASE;
          end else if (i_r <= r_r - 1'b1 && i_r < r_r) begin
            mop_r <= M_SQX;
            mx_r <= x_r;
            my_r <= x_r;
            mp_r <= '0;
            bit_r <= mrpt_pkg::BIT_W'(mrpt_pkg::WIDTH - 1);
            state_r <= S_MUL_DBL;
          end else begin
            prime_r <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the result until its transfer completes
          if (!out_valid_r) out_valid_r <= 1'b1;
          else if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result valid outside output state");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready) else $error("input ready while result pending");
  a_mul_lt_n: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_DBL || state_r == S_MUL_ADD) |-> mp_r < n_r)
    else $error("partial product not reduced");
endmodule
